### hdl/disk_cluster_allocator_core_defines.svh
// assertion macros for the disk cluster allocator checker
// no dependencies; expects aclk and aresetn in the scope of use
`ifndef DISK_CLUSTER_ALLOCATOR_CORE_DEFINES_SVH
`define DISK_CLUSTER_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DCA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DCA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dca_pkg.sv
// shared types and constants for the disk cluster allocator
// no dependencies
package dca_pkg;

    // fixed field widths
    localparam int CYL_IN_W   = 3;
    localparam int TRK_IN_W   = 2;
    localparam int SLOT_IN_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int SECTOR_W   = 6;
    localparam int INDEX_W    = 11;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int M_FIELDS_W = CYL_IN_W + TRK_IN_W + SECTOR_W + INDEX_W;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_CLAIMED    = 2'd0,
        ST_FULL       = 2'd1,
        ST_NO_CLUSTER = 2'd2
    } alloc_status_t;

    // controller states
    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_REDUCE,
        CTL_SCAN,
        CTL_POST_OK,
        CTL_POST_FULL,
        CTL_POST_NONE
    } dca_state_t;

    // controller to datapath
    typedef struct packed {
        logic          clear_step;
        logic          load;
        logic          reduce;
        logic          issue;
        logic          post;
        alloc_status_t code;
    } dca_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic full;
        logic no_slots;
        logic in_range;
        logic hit;
        logic swept;
        logic out_free;
    } dca_stat_t;

endpackage

### hdl/dca_ctrl.sv
// controller state machine for the disk cluster allocator
// depends on dca_pkg
module dca_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dca_pkg::dca_stat_t  stat,
    output dca_pkg::dca_cmd_t   cmd
);

    dca_pkg::dca_state_t state_reg;
    dca_pkg::dca_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dca_pkg::CTL_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dca_pkg::CTL_CLEAR: begin
                if (stat.clear_last) state_next = dca_pkg::CTL_IDLE;
            end
            dca_pkg::CTL_IDLE: begin
                if (s_tvalid) begin
                    if (stat.full) begin
                        state_next = dca_pkg::CTL_POST_FULL;
                    end else if (stat.no_slots) begin
                        state_next = dca_pkg::CTL_POST_NONE;
                    end else begin
                        state_next = dca_pkg::CTL_REDUCE;
                    end
                end
            end
            dca_pkg::CTL_REDUCE: begin
                if (stat.in_range) state_next = dca_pkg::CTL_SCAN;
            end
            dca_pkg::CTL_SCAN: begin
                if (stat.hit) begin
                    state_next = dca_pkg::CTL_POST_OK;
                end else if (stat.swept) begin
                    state_next = dca_pkg::CTL_POST_NONE;
                end
            end
            dca_pkg::CTL_POST_OK,
            dca_pkg::CTL_POST_FULL,
            dca_pkg::CTL_POST_NONE: begin
                if (stat.out_free) state_next = dca_pkg::CTL_IDLE;
            end
            default: state_next = dca_pkg::CTL_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        cmd            = '0;
        cmd.code       = dca_pkg::ST_CLAIMED;
        s_tready       = 1'b0;
        unique case (state_reg)
            dca_pkg::CTL_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            dca_pkg::CTL_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            dca_pkg::CTL_REDUCE: begin
                cmd.reduce = 1'b1;
            end
            dca_pkg::CTL_SCAN: begin
                cmd.issue = !stat.hit && !stat.swept;
            end
            dca_pkg::CTL_POST_OK: begin
                cmd.post = stat.out_free;
                cmd.code = dca_pkg::ST_CLAIMED;
            end
            dca_pkg::CTL_POST_FULL: begin
                cmd.post = stat.out_free;
                cmd.code = dca_pkg::ST_FULL;
            end
            dca_pkg::CTL_POST_NONE: begin
                cmd.post = stat.out_free;
                cmd.code = dca_pkg::ST_NO_CLUSTER;
            end
            default: begin
                cmd.clear_step = 1'b0;
            end
        endcase
    end

endmodule

### hdl/dca_datapath.sv
// datapath for the disk cluster allocator: cluster used map, position counters,
// result register; depends on dca_pkg
module dca_datapath #(
    parameter int CYLINDERS = 8,
    parameter int TRACKS    = 4,
    parameter int SECTORS   = 64,
    parameter int CLUSTER   = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  dca_pkg::dca_cmd_t                      cmd,
    output dca_pkg::dca_stat_t                     stat,
    input  logic [dca_pkg::CYL_IN_W-1:0]           in_cylinder,
    input  logic [dca_pkg::TRK_IN_W-1:0]           in_track,
    input  logic [dca_pkg::SLOT_IN_W-1:0]          in_slot,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [dca_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [dca_pkg::STATUS_W-1:0]           m_tuser
);

    // geometry
    localparam int SLOTS   = SECTORS / CLUSTER;
    localparam int CYL_POS = TRACKS * SLOTS;
    localparam int NPOS    = CYLINDERS * CYL_POS;
    localparam int MEM_D   = (NPOS > 0) ? NPOS : 1;
    localparam bit EXACT   = (SLOTS > 0) && (SLOTS * CLUSTER == SECTORS);

    // widths
    localparam int CYL_W  = ($clog2(CYLINDERS) > dca_pkg::CYL_IN_W) ?
                            $clog2(CYLINDERS) : dca_pkg::CYL_IN_W;
    localparam int TRK_W  = ($clog2(TRACKS) > dca_pkg::TRK_IN_W) ?
                            $clog2(TRACKS) : dca_pkg::TRK_IN_W;
    localparam int SLOT_W = ($clog2(SLOTS) > dca_pkg::SLOT_IN_W) ?
                            $clog2(SLOTS) : dca_pkg::SLOT_IN_W;
    localparam int C_W    = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
    localparam int K_W    = (CYL_POS > 1) ? $clog2(CYL_POS) : 1;
    localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int CNT_W  = $clog2(MEM_D + 1);
    localparam int IW     = dca_pkg::INDEX_W;

    // sized constants
    localparam logic [CYL_W:0]    CYL_LIM  = (CYL_W + 1)'(CYLINDERS);
    localparam logic [TRK_W:0]    TRK_LIM  = (TRK_W + 1)'(TRACKS);
    localparam logic [SLOT_W:0]   SLOT_LIM = (SLOT_W + 1)'(SLOTS);
    localparam logic [CYL_W-1:0]  CYL_MAX  = CYL_W'(CYLINDERS - 1);
    localparam logic [TRK_W-1:0]  TRK_MAX  = TRK_W'(TRACKS - 1);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS - 1);
    localparam logic [C_W-1:0]    C_LAST   = C_W'(CYLINDERS - 1);
    localparam logic [K_W-1:0]    K_LAST   = K_W'(CYL_POS - 1);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_D - 1);
    localparam logic [CNT_W-1:0]  CNT_ALL  = CNT_W'(NPOS);
    localparam logic [ADDR_W-1:0] A_CYL    = ADDR_W'(CYL_POS);
    localparam logic [ADDR_W-1:0] A_TRK    = ADDR_W'(TRACKS);
    localparam logic [IW-1:0]     I_CYL    = IW'(TRACKS * SECTORS);
    localparam logic [IW-1:0]     I_TRK    = IW'(SECTORS);
    localparam logic [IW-1:0]     I_CLU    = IW'(CLUSTER);

    // cluster used map, one bit per cluster position
    logic mem [0:MEM_D-1];
    logic rd_data_reg;

    logic [ADDR_W-1:0] clr_reg,  clr_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [CYL_W-1:0]  cyl_reg,  cyl_next;
    logic [TRK_W-1:0]  trk_reg,  trk_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [C_W-1:0]    c_reg,    c_next;
    logic [K_W-1:0]    k_reg,    k_next;
    logic              swept_reg, swept_next;
    logic              pipe_valid_reg;
    logic [CYL_W-1:0]  pipe_cyl_reg;
    logic [TRK_W-1:0]  pipe_trk_reg;
    logic [SLOT_W-1:0] pipe_slot_reg;
    logic [ADDR_W-1:0] pipe_addr_reg;
    logic              out_valid_reg, out_valid_next;
    logic [dca_pkg::STATUS_W-1:0]   out_status_reg;
    logic [dca_pkg::M_FIELDS_W-1:0] out_fields_reg;

    logic              cyl_ge, trk_ge, slot_ge;
    logic [ADDR_W-1:0] cur_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              claim;
    logic [IW-1:0]     sec_idx, base_idx;
    logic [dca_pkg::M_FIELDS_W-1:0] res_fields;

    // range checks for start reduction
    assign cyl_ge  = ({1'b0, cyl_reg}  >= CYL_LIM);
    assign trk_ge  = ({1'b0, trk_reg}  >= TRK_LIM);
    assign slot_ge = ({1'b0, slot_reg} >= SLOT_LIM);

    // memory address of the current position
    assign cur_addr = ADDR_W'(cyl_reg) * A_CYL + ADDR_W'(slot_reg) * A_TRK
                    + ADDR_W'(trk_reg);

    // position walk and start reduction
    always_comb begin
        cyl_next   = cyl_reg;
        trk_next   = trk_reg;
        slot_next  = slot_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        swept_next = swept_reg;
        if (cmd.load) begin
            cyl_next   = CYL_W'(in_cylinder);
            trk_next   = TRK_W'(in_track);
            slot_next  = SLOT_W'(in_slot);
            c_next     = '0;
            k_next     = '0;
            swept_next = 1'b0;
        end else if (cmd.reduce) begin
            if (cyl_ge)  cyl_next  = cyl_reg  - CYL_LIM[CYL_W-1:0];
            if (trk_ge)  trk_next  = trk_reg  - TRK_LIM[TRK_W-1:0];
            if (slot_ge) slot_next = slot_reg - SLOT_LIM[SLOT_W-1:0];
        end else if (cmd.issue) begin
            if (k_reg == K_LAST) begin
                // cylinder done: next cylinder from its first position
                k_next    = '0;
                c_next    = c_reg + 1'b1;
                cyl_next  = (cyl_reg == CYL_MAX) ? '0 : cyl_reg + 1'b1;
                trk_next  = '0;
                slot_next = '0;
                if (c_reg == C_LAST) swept_next = 1'b1;
            end else begin
                k_next = k_reg + 1'b1;
                if (trk_reg == TRK_MAX) begin
                    trk_next  = '0;
                    slot_next = (slot_reg == SLOT_MAX) ? '0 : slot_reg + 1'b1;
                end else begin
                    trk_next = trk_reg + 1'b1;
                end
            end
        end
    end

    // result fields from the position under test
    assign claim    = cmd.post && (cmd.code == dca_pkg::ST_CLAIMED);
    assign sec_idx  = IW'(pipe_slot_reg) * I_CLU;
    assign base_idx = IW'(pipe_cyl_reg) * I_CYL + IW'(pipe_trk_reg) * I_TRK + sec_idx;
    assign res_fields = {base_idx,
                         sec_idx[dca_pkg::SECTOR_W-1:0],
                         pipe_trk_reg[dca_pkg::TRK_IN_W-1:0],
                         pipe_cyl_reg[dca_pkg::CYL_IN_W-1:0]};

    // clear sweep, used count and output valid
    always_comb begin
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.clear_step) clr_next = clr_reg + 1'b1;
        if (claim) cnt_next = cnt_reg + 1'b1;
        if (cmd.post) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // memory write port
    assign wr_en   = cmd.clear_step || claim;
    assign wr_addr = cmd.clear_step ? clr_reg : pipe_addr_reg;

    // used map storage with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= !cmd.clear_step;
        rd_data_reg <= mem[cur_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg        <= '0;
            cnt_reg        <= '0;
            swept_reg      <= 1'b0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            clr_reg        <= clr_next;
            cnt_reg        <= cnt_next;
            swept_reg      <= swept_next;
            pipe_valid_reg <= cmd.issue;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cyl_reg  <= cyl_next;
        trk_reg  <= trk_next;
        slot_reg <= slot_next;
        c_reg    <= c_next;
        k_reg    <= k_next;
        if (cmd.issue) begin
            pipe_cyl_reg  <= cyl_reg;
            pipe_trk_reg  <= trk_reg;
            pipe_slot_reg <= slot_reg;
            pipe_addr_reg <= cur_addr;
        end
        if (cmd.post) begin
            out_status_reg <= cmd.code;
            out_fields_reg <= claim ? res_fields : '0;
        end
    end

    // status to controller
    always_comb begin
        stat            = '0;
        stat.clear_last = (clr_reg == CLR_LAST);
        stat.full       = EXACT && (cnt_reg == CNT_ALL);
        stat.no_slots   = (SLOTS == 0);
        stat.in_range   = !(cyl_ge || trk_ge || slot_ge);
        stat.hit        = pipe_valid_reg && !rd_data_reg;
        stat.swept      = swept_reg;
        stat.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(dca_pkg::M_TDATA_W - dca_pkg::M_FIELDS_W){1'b0}}, out_fields_reg};

endmodule

### hdl/disk_cluster_allocator_core.sv
// disk cluster allocator top level: controller plus datapath; depends on dca_pkg
// sequence: accept, reduce the start into range one step at a time, test positions through the
//   registered map read, then post once the output is free; a full disk posts without a scan
// throughput: one request at a time, worst case a sweep of all CYLINDERS*TRACKS*SECTORS/CLUSTER
//   positions, set by the single used map read port, one position per cycle
// reset: control state clears, then the map clears one entry per cycle (512 entries at default sizes), s_tready low
module disk_cluster_allocator_core #(
    parameter int CYLINDERS = 8,
    parameter int TRACKS    = 4,
    parameter int SECTORS   = 64,
    parameter int CLUSTER   = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_cylinder[2:0], start_track[4:3], start_slot[8:5], zero pad
    input  logic [dca_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found_cylinder[2:0], found_track[4:3], found_sector[10:5],
    // first_index[21:11], zero pad
    output logic [dca_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [dca_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int TRK_LO  = dca_pkg::CYL_IN_W;
    localparam int SLOT_LO = dca_pkg::CYL_IN_W + dca_pkg::TRK_IN_W;

    dca_pkg::dca_cmd_t  cmd;
    dca_pkg::dca_stat_t stat;

    // sequencer
    dca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // map, counters and result register
    dca_datapath #(
        .CYLINDERS (CYLINDERS),
        .TRACKS    (TRACKS),
        .SECTORS   (SECTORS),
        .CLUSTER   (CLUSTER)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_cylinder (s_tdata[dca_pkg::CYL_IN_W-1:0]),
        .in_track    (s_tdata[TRK_LO +: dca_pkg::TRK_IN_W]),
        .in_slot     (s_tdata[SLOT_LO +: dca_pkg::SLOT_IN_W]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### hdl/dca_checker.sv
// port-level checks for the disk cluster allocator, bound to the top level
// depends on dca_pkg and disk_cluster_allocator_core_defines.svh
`include "disk_cluster_allocator_core_defines.svh"

module dca_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dca_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [dca_pkg::STATUS_W-1:0]    m_tuser
);

    // a stalled result word holds
    `DCA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // one request at a time: busy right after an accept
    `DCA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input ready while a request is in work")

    // failed requests carry no coordinates
    `DCA_ASSERT_IMP(a_fail_zero, m_tvalid && (m_tuser != dca_pkg::ST_CLAIMED), m_tdata == '0, "nonzero fields on a failed allocation")

endmodule

bind disk_cluster_allocator_core dca_checker u_dca_checker (.*);
